[sv/bdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Command and status codes and the result record of the deque; its checker
// uses the status codes.
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned POS_W   = 8;

  typedef struct packed {
    logic                 data_valid;
    status_t              status;
    logic [COUNT_W-1:0]   count_now;
  } result_t;

endpackage

[sv/bounded_deque_with_index_read_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with index read
// Circular store with a head pointer and a count; inserts, removes and reads
// at either end or by index, one result per request.
// ----------------------------------------------------------------------------
// Each accepted request is registered in stage s1, then in the output stage.
// Throughput: one request per cycle while in_stall is low; the single-port
// store is read or written once at acceptance, which also registers read data.
// Reset clears the head pointer, the count and both pipeline valids; the
// element store is not cleared and holds whatever it held.
module bounded_deque_with_index_read_unit #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_cmd,
  input  logic [bdq_pkg::DATA_W-1:0]    in_element,
  input  logic [bdq_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::DATA_W-1:0]    out_read_data,
  output logic                          out_data_valid,
  output logic [1:0]                    out_status,
  output logic [bdq_pkg::COUNT_W-1:0]   out_count_now
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  logic [ELEM_WIDTH-1:0] mem_r [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  bdq_pkg::result_t   s1_res_r, s1_res_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bdq_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  bdq_pkg::result_t             out_res_r, out_res_nxt;

  logic          advance;
  logic          accept;
  logic          full;
  logic          empty;
  logic          pos_ok;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [ELEM_WIDTH-1:0] wdata;
  bdq_pkg::cmd_t cmd;
  bdq_pkg::result_t res;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign cmd    = bdq_pkg::cmd_t'(in_cmd);
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_ok = CMPW'(in_position) < CMPW'(count_r);
  assign wdata  = ELEM_WIDTH'(in_element);

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = head_r;
    res.data_valid = 1'b0;
    res.status     = bdq_pkg::ST_OK;
    case (cmd)
      bdq_pkg::CMD_INS_HEAD: begin
        if (full) begin
          res.status = bdq_pkg::ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
          mem_addr  = head_nxt;
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::CMD_INS_TAIL: begin
        if (full) begin
          res.status = bdq_pkg::ST_FULL;
        end else begin
          mem_addr  = slot_of(head_r, count_r);
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::CMD_REM_HEAD: begin
        if (empty) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          head_nxt  = slot_of(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      bdq_pkg::CMD_REM_TAIL: begin
        if (empty) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      bdq_pkg::CMD_RD_HEAD: begin
        if (empty) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          mem_addr       = head_r;
          mem_re         = 1'b1;
          res.data_valid = 1'b1;
        end
      end
      bdq_pkg::CMD_RD_TAIL: begin
        if (empty) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          mem_addr       = slot_of(head_r, count_r - CW'(1));
          mem_re         = 1'b1;
          res.data_valid = 1'b1;
        end
      end
      bdq_pkg::CMD_RD_INDEX: begin
        if (!pos_ok) begin
          res.status = bdq_pkg::ST_RANGE;
        end else begin
          mem_addr       = slot_of(head_r, CW'(in_position));
          mem_re         = 1'b1;
          res.data_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count_now = bdq_pkg::COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem_r[mem_addr] <= wdata;
    end
    if (accept && mem_re) begin
      rdata_r <= mem_r[mem_addr];
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_res_nxt    = s1_res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_res_nxt   = out_res_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      out_res_nxt   = s1_res_r;
      out_data_nxt  = s1_res_r.data_valid ? bdq_pkg::DATA_W'(rdata_r) : '0;
      s1_valid_nxt  = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_res_r   <= s1_res_nxt;
    out_res_r  <= out_res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_data_valid = out_res_r.data_valid;
  assign out_status     = out_res_r.status;
  assign out_count_now  = out_res_r.count_now;

endmodule

[sv/bdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque checker
// Port-level properties of the result channel, bound to the deque top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bdq_pkg::DATA_W-1:0]    out_read_data,
  input logic                          out_data_valid,
  input logic [1:0]                    out_status,
  input logic [bdq_pkg::COUNT_W-1:0]   out_count_now
);

  localparam logic [bdq_pkg::COUNT_W-1:0] CAP_CNT = bdq_pkg::COUNT_W'(CAPACITY);

  a_data_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status == bdq_pkg::ST_OK)
    else $error("data returned with a failing status");

  a_zero_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_read_data == '0)
    else $error("read data not zero without data");

  a_full_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bdq_pkg::ST_FULL |-> out_count_now == CAP_CNT)
    else $error("full status with a count below capacity");

  a_empty_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bdq_pkg::ST_EMPTY |-> out_count_now == '0)
    else $error("empty status with a nonzero count");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
      $stable(out_count_now))
    else $error("stalled result changed");

endmodule

bind bounded_deque_with_index_read_unit bdq_checker #(
  .CAPACITY (CAPACITY)
) u_bdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_data_valid (out_data_valid),
  .out_status     (out_status),
  .out_count_now  (out_count_now)
);
